### design/pnm_pkg.sv
// package with phase, result kind and byte constants for the pnm header and sample parser
package pnm_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_FORMAT  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_SAMPLES = 3'd3,
    PH_IDLE    = 3'd4
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // error codes
  localparam logic ERR_MAGIC  = 1'b0;
  localparam logic ERR_FORMAT = 1'b1;

  // header field slots
  localparam logic [1:0] FIELD_WIDTH  = 2'd0;
  localparam logic [1:0] FIELD_HEIGHT = 2'd1;
  localparam logic [1:0] FIELD_MAXVAL = 2'd2;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  // default decimal accumulator width
  localparam int NUMBER_BITS_DEFAULT = 16;

endpackage

### design/pnm_header_and_sample_parser_core.sv
// pnm (P5/P6) header parser and sample splitter, one byte per cycle while in_ready is high
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  input   | in_valid, in_ready, data_byte, start_req       | in
//  result  | out_valid, out_ready, kind, error_code,        | out
//          | channels, width, height, max_value, sample,last|
//
// one byte is taken per cycle while in_ready is high, i.e. whenever the output
// register is empty or being drained; each transfer updates the parse state in
// the same cycle and loads at most one result into the output register, so a
// result appears the cycle after its byte. width*height is multiplied when
// height completes. rst (synchronous) returns the parser to expect 'P'.
module pnm_header_and_sample_parser_core
  import pnm_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        error_code,
  output logic [1:0]  channels,
  output logic [15:0] width,
  output logic [15:0] height,
  output logic [15:0] max_value,
  output logic [15:0] sample,
  output logic        last
);

  localparam int AW = NUMBER_BITS;
  localparam int EW = NUMBER_BITS + 16;

  // parse state
  phase_t      phase, phase_next;
  logic        in_comment, in_comment_next;
  logic [AW-1:0] accumulator, accumulator_next;
  logic        in_digits, in_digits_next;
  logic [1:0]  field_index, field_index_next;
  logic [15:0] held_width, held_width_next;
  logic [15:0] held_height, held_height_next;
  logic [15:0] held_maxval, held_maxval_next;
  logic [1:0]  held_channels, held_channels_next;
  logic [7:0]  high_byte, high_byte_next;
  logic        byte_parity, byte_parity_next;
  logic [33:0] samples_left, samples_left_next;
  logic [31:0] wh_product, wh_product_next;

  // state seen by this byte (cleared on start_req)
  phase_t      cur_phase;
  logic        cur_comment, cur_digits, cur_parity;
  logic [AW-1:0] cur_acc;
  logic [1:0]  cur_field, cur_channels;
  logic [15:0] cur_width, cur_height, cur_maxval;
  logic [33:0] cur_left;
  logic [31:0] cur_product;

  logic        accept;
  logic        is_digit, is_blank, is_hash;
  logic [3:0]  digit_val;
  logic [AW+3:0] acc_times_ten;
  logic [AW+4:0] acc_sum;
  logic [AW-1:0] acc_step;
  logic        finish;
  logic [AW-1:0] finish_raw;
  logic [EW-1:0] finish_ext;
  logic [15:0] finish_val;
  logic [33:0] total_samples;
  logic        wide_samples;
  logic        sample_emit;
  logic [33:0] left_dec;

  // result staged for the output register
  logic        res_valid;
  logic [1:0]  res_kind;
  logic        res_error;
  logic [1:0]  res_channels;
  logic [15:0] res_width, res_height, res_maxval, res_sample;
  logic        res_last;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // restart clears the state before the byte is used
  always_comb begin
    if (start_req) begin
      cur_phase    = PH_MAGIC;
      cur_comment  = 1'b0;
      cur_acc      = '0;
      cur_digits   = 1'b0;
      cur_field    = FIELD_WIDTH;
      cur_width    = '0;
      cur_height   = '0;
      cur_maxval   = '0;
      cur_channels = 2'd1;
      cur_parity   = 1'b0;
      cur_left     = '0;
      cur_product  = '0;
    end else begin
      cur_phase    = phase;
      cur_comment  = in_comment;
      cur_acc      = accumulator;
      cur_digits   = in_digits;
      cur_field    = field_index;
      cur_width    = held_width;
      cur_height   = held_height;
      cur_maxval   = held_maxval;
      cur_channels = held_channels;
      cur_parity   = byte_parity;
      cur_left     = samples_left;
      cur_product  = wh_product;
    end
  end

  // byte classes
  assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
  assign is_blank  = (data_byte == CH_LF) || (data_byte == CH_CR) ||
                     (data_byte == CH_TAB) || (data_byte == CH_SPACE);
  assign is_hash   = (data_byte == CH_HASH);
  assign digit_val = 4'(data_byte - CH_0);

  // saturating decimal accumulate
  assign acc_times_ten = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0};
  assign acc_sum       = {1'b0, acc_times_ten} + (AW+5)'(digit_val);
  assign acc_step      = (acc_sum[AW+4:AW] != '0) ? {AW{1'b1}} : acc_sum[AW-1:0];

  // number end and its value clipped to 16 bits
  assign finish = (cur_phase == PH_HEADER) && !cur_comment &&
                  ((cur_digits && !is_digit) ||
                   (!cur_digits && !is_hash && !is_blank && !is_digit));
  assign finish_raw = cur_digits ? cur_acc : '0;
  assign finish_ext = EW'(finish_raw);
  assign finish_val = (finish_ext > EW'(16'hFFFF)) ? 16'hFFFF : finish_ext[15:0];

  // component count, channels is 1 or 3
  assign total_samples = cur_channels[1] ? (34'(cur_product) + {1'b0, cur_product, 1'b0})
                                         : 34'(cur_product);

  // sample splitting
  assign wide_samples = (cur_maxval[15:8] != 8'h00);
  assign sample_emit  = (cur_phase == PH_SAMPLES) && (!wide_samples || cur_parity);
  assign left_dec     = (cur_left != '0) ? (cur_left - 34'd1) : cur_left;

  // next state
  always_comb begin
    phase_next         = cur_phase;
    in_comment_next    = cur_comment;
    accumulator_next   = cur_acc;
    in_digits_next     = cur_digits;
    field_index_next   = cur_field;
    held_width_next    = cur_width;
    held_height_next   = cur_height;
    held_maxval_next   = cur_maxval;
    held_channels_next = cur_channels;
    high_byte_next     = high_byte;
    byte_parity_next   = cur_parity;
    samples_left_next  = cur_left;
    wh_product_next    = cur_product;
    case (cur_phase)
      PH_MAGIC: begin
        phase_next = (data_byte == CH_P) ? PH_FORMAT : PH_IDLE;
      end
      PH_FORMAT: begin
        if (data_byte == CH_5 || data_byte == CH_6) begin
          held_channels_next = (data_byte == CH_5) ? 2'd1 : 2'd3;
          phase_next         = PH_HEADER;
          in_comment_next    = 1'b0;
          in_digits_next     = 1'b0;
          accumulator_next   = '0;
          field_index_next   = FIELD_WIDTH;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_HEADER: begin
        if (cur_comment) begin
          if (data_byte == CH_LF) in_comment_next = 1'b0;
        end else if (cur_digits && is_digit) begin
          accumulator_next = acc_step;
        end else if (!cur_digits && is_hash) begin
          in_comment_next = 1'b1;
        end else if (!cur_digits && is_digit) begin
          accumulator_next = AW'(digit_val);
          in_digits_next   = 1'b1;
        end
        // store a finished number
        if (finish) begin
          in_digits_next   = 1'b0;
          accumulator_next = '0;
          case (cur_field)
            FIELD_WIDTH: begin
              held_width_next  = finish_val;
              field_index_next = FIELD_HEIGHT;
              if (is_hash) in_comment_next = 1'b1;
            end
            FIELD_HEIGHT: begin
              held_height_next = finish_val;
              field_index_next = FIELD_MAXVAL;
              wh_product_next  = 32'(cur_width) * 32'(finish_val);
              if (is_hash) in_comment_next = 1'b1;
            end
            default: begin
              held_maxval_next  = finish_val;
              field_index_next  = FIELD_WIDTH;
              in_comment_next   = 1'b0;
              samples_left_next = total_samples;
              byte_parity_next  = 1'b0;
              phase_next        = (total_samples != '0) ? PH_SAMPLES : PH_IDLE;
            end
          endcase
        end
      end
      PH_SAMPLES: begin
        if (wide_samples && !cur_parity) begin
          high_byte_next   = data_byte;
          byte_parity_next = 1'b1;
        end else begin
          byte_parity_next  = 1'b0;
          samples_left_next = left_dec;
          if (left_dec == '0) phase_next = PH_IDLE;
        end
      end
      default: begin
        phase_next = cur_phase;
      end
    endcase
  end

  // result for this byte, unused fields zero
  always_comb begin
    res_valid    = 1'b0;
    res_kind     = KIND_HEADER;
    res_error    = ERR_MAGIC;
    res_channels = '0;
    res_width    = '0;
    res_height   = '0;
    res_maxval   = '0;
    res_sample   = '0;
    res_last     = 1'b0;
    case (cur_phase)
      PH_MAGIC: begin
        if (data_byte != CH_P) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_error = ERR_MAGIC;
        end
      end
      PH_FORMAT: begin
        if (data_byte != CH_5 && data_byte != CH_6) begin
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_error = ERR_FORMAT;
        end
      end
      PH_HEADER: begin
        if (finish && cur_field != FIELD_WIDTH && cur_field != FIELD_HEIGHT) begin
          res_valid    = 1'b1;
          res_kind     = KIND_HEADER;
          res_channels = cur_channels;
          res_width    = cur_width;
          res_height   = cur_height;
          res_maxval   = finish_val;
        end
      end
      PH_SAMPLES: begin
        if (sample_emit) begin
          res_valid  = 1'b1;
          res_kind   = KIND_SAMPLE;
          res_sample = wide_samples ? {high_byte, data_byte} : {8'h00, data_byte};
          res_last   = (left_dec == '0);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MAGIC;
      in_comment    <= 1'b0;
      accumulator   <= '0;
      in_digits     <= 1'b0;
      field_index   <= FIELD_WIDTH;
      held_width    <= '0;
      held_height   <= '0;
      held_maxval   <= '0;
      held_channels <= 2'd1;
      high_byte     <= '0;
      byte_parity   <= 1'b0;
      samples_left  <= '0;
      wh_product    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      in_comment    <= in_comment_next;
      accumulator   <= accumulator_next;
      in_digits     <= in_digits_next;
      field_index   <= field_index_next;
      held_width    <= held_width_next;
      held_height   <= held_height_next;
      held_maxval   <= held_maxval_next;
      held_channels <= held_channels_next;
      high_byte     <= high_byte_next;
      byte_parity   <= byte_parity_next;
      samples_left  <= samples_left_next;
      wh_product    <= wh_product_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind       <= res_kind;
      error_code <= res_error;
      channels   <= res_channels;
      width      <= res_width;
      height     <= res_height;
      max_value  <= res_maxval;
      sample     <= res_sample;
      last       <= res_last;
    end
  end

endmodule

### dv/testbench.sv
// self-checking testbench for the pnm header and sample parser core
`timescale 1ns / 1ps

module testbench
  import pnm_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 125;

  typedef struct packed {
    kind_t       kind;
    logic        error_code;
    logic [1:0]  channels;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] max_value;
    logic [15:0] sample;
    logic        last;
  } pnm_result_t;

  typedef struct {
    bit [7:0] data;
    bit       first;
    bit       wait_drain;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        start_req = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        error_code;
  logic [1:0]  channels;
  logic [15:0] width;
  logic [15:0] height;
  logic [15:0] max_value;
  logic [15:0] sample;
  logic        last;

  pnm_header_and_sample_parser_core uut (.*);

  // stimulus and pacing
  stream_byte_t byte_q[$];
  stream_byte_t cur_byte;
  bit           drain_next = 1'b0;
  int unsigned  bytes_queued = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  logic         in_taken = 1'b0;

  // scoreboard
  pnm_result_t  expected_results[$];
  pnm_result_t  want;
  pnm_result_t  got;
  int           errors = 0;
  int           cycles = 0;

  // parser model state
  phase_t       ph;
  bit           in_comment;
  bit           in_digits;
  bit           pair_odd;
  bit [15:0]    acc;
  bit [15:0]    held_w;
  bit [15:0]    held_h;
  bit [15:0]    held_max;
  bit [1:0]     field;
  bit [1:0]     held_ch;
  bit [7:0]     hi_byte;
  bit [33:0]    samples_left;

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // parser model: back to waiting for the magic letter
  function automatic void restart_parse();
    ph = PH_MAGIC;
    in_comment = 1'b0;
    in_digits = 1'b0;
    pair_odd = 1'b0;
    acc = '0;
    held_w = '0;
    held_h = '0;
    held_max = '0;
    field = FIELD_WIDTH;
    held_ch = 2'd1;
    hi_byte = '0;
    samples_left = '0;
  endfunction

  // store a finished header number, header result once maxval is in
  function automatic void close_number(bit [15:0] v);
    pnm_result_t r;
    r = '0;
    in_digits = 1'b0;
    acc = '0;
    case (field)
      FIELD_WIDTH: begin
        held_w = v;
        field = FIELD_HEIGHT;
      end
      FIELD_HEIGHT: begin
        held_h = v;
        field = FIELD_MAXVAL;
      end
      default: begin
        held_max = v;
        field = FIELD_WIDTH;
        in_comment = 1'b0;
        samples_left = 34'(held_w) * 34'(held_h) * 34'(held_ch);
        pair_odd = 1'b0;
        ph = (samples_left != 0) ? PH_SAMPLES : PH_IDLE;
        r.kind = KIND_HEADER;
        r.channels = held_ch;
        r.width = held_w;
        r.height = held_h;
        r.max_value = held_max;
        expected_results.push_back(r);
      end
    endcase
  endfunction

  // parser model: one byte in, expected result queued if any
  function automatic void parse_byte(bit [7:0] c, bit s);
    pnm_result_t r;
    bit          digit;
    int unsigned nxt;
    r = '0;
    digit = (c >= CH_0) && (c <= CH_9);
    if (s) restart_parse();
    case (ph)
      PH_MAGIC: begin
        if (c == CH_P) begin
          ph = PH_FORMAT;
        end else begin
          ph = PH_IDLE;
          r.kind = KIND_ERROR;
          r.error_code = ERR_MAGIC;
          expected_results.push_back(r);
        end
      end
      PH_FORMAT: begin
        if (c == CH_5 || c == CH_6) begin
          held_ch = (c == CH_5) ? 2'd1 : 2'd3;
          ph = PH_HEADER;
          in_comment = 1'b0;
          in_digits = 1'b0;
          acc = '0;
          field = FIELD_WIDTH;
        end else begin
          ph = PH_IDLE;
          r.kind = KIND_ERROR;
          r.error_code = ERR_FORMAT;
          expected_results.push_back(r);
        end
      end
      PH_HEADER: begin
        if (in_comment) begin
          if (c == CH_LF) in_comment = 1'b0;
        end else if (in_digits) begin
          if (digit) begin
            nxt = 32'(acc) * 32'd10 + 32'(c - CH_0);
            acc = (nxt > 32'd65535) ? 16'hffff : nxt[15:0];
          end else if (field < FIELD_MAXVAL && c == CH_HASH) begin
            // hash right after width or height digits opens a comment
            close_number(acc);
            in_comment = 1'b1;
          end else begin
            close_number(acc);
          end
        end else if (c == CH_HASH) begin
          in_comment = 1'b1;
        end else if (c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_SPACE) begin
          // whitespace between numbers
        end else if (digit) begin
          acc = 16'(c - CH_0);
          in_digits = 1'b1;
        end else begin
          // stray byte where a number should begin counts as zero
          close_number(16'd0);
        end
      end
      PH_SAMPLES: begin
        if (held_max >= 16'd256 && !pair_odd) begin
          hi_byte = c;
          pair_odd = 1'b1;
        end else begin
          r.sample = (held_max >= 16'd256) ? {hi_byte, c} : {8'd0, c};
          pair_odd = 1'b0;
          if (samples_left != 0) samples_left--;
          r.kind = KIND_SAMPLE;
          r.last = (samples_left == 0);
          if (samples_left == 0) ph = PH_IDLE;
          expected_results.push_back(r);
        end
      end
      default: begin
        // idle until the next start
      end
    endcase
  endfunction

  // input transfers feed the model, output transfers are checked
  always @(posedge clk) begin
    if (rst) begin
      restart_parse();
      expected_results.delete();
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {kind, error_code, channels, width, height, max_value, sample, last};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, kind=%0d sample=%h", $time, kind, sample);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind=%0d err=%0d ch=%0d w=%0d h=%0d max=%0d",
                     $time, want.kind, want.error_code, want.channels, want.width,
                     want.height, want.max_value, " sample=%h last=%0d", want.sample,
                     want.last);
            $display("%0t:          actual kind=%0d err=%0d ch=%0d w=%0d h=%0d max=%0d",
                     $time, kind, error_code, channels, width, height, max_value,
                     " sample=%h last=%0d", sample, last);
          end
        end
      end
      if (in_valid && in_ready) parse_byte(data_byte, start_req);
      in_taken <= in_valid && in_ready;
    end
  end

  // byte driver, holds valid until transfer
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // payload stays put until the transfer
    end else if (byte_q.size() != 0
                 && !(byte_q[0].wait_drain && expected_results.size() != 0)
                 && $urandom_range(99) >= send_idle_pct) begin
      cur_byte = byte_q.pop_front();
      in_valid <= 1'b1;
      data_byte <= cur_byte.data;
      start_req <= cur_byte.first;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_byte(bit [7:0] b, bit s);
    stream_byte_t e;
    e.data = b;
    e.first = s;
    e.wait_drain = drain_next;
    drain_next = 1'b0;
    byte_q.push_back(e);
    bytes_queued++;
  endtask

  task automatic push_text(string t);
    for (int i = 0; i < t.len(); i++) push_byte(t[i], 1'b0);
  endtask

  function automatic bit [7:0] random_blank();
    case ($urandom_range(3))
      0: return CH_LF;
      1: return CH_CR;
      2: return CH_TAB;
      default: return CH_SPACE;
    endcase
  endfunction

  // any byte that is not a digit, whitespace or hash
  function automatic bit [7:0] random_stray();
    bit [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while ((b >= CH_0 && b <= CH_9) || b == CH_HASH || b == CH_LF || b == CH_CR
               || b == CH_TAB || b == CH_SPACE);
    return b;
  endfunction

  function automatic bit [7:0] comment_byte();
    bit [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == CH_LF);
    return b;
  endfunction

  // one file: mostly well formed with random layout and data, some broken
  task automatic add_random_file();
    bit [7:0]    f[$];
    longint      vals[3];
    longint      n_data;
    int unsigned chans;
    int unsigned style;
    int unsigned flaw;
    string       txt;
    bit [7:0]    b;
    chans = $urandom_range(1) ? 3 : 1;
    f.push_back(CH_P);
    f.push_back(chans == 3 ? CH_6 : CH_5);
    vals[0] = $urandom_range(4);
    vals[1] = $urandom_range(3);
    vals[2] = $urandom_range(1) ? $urandom_range(255) : $urandom_range(65535, 256);
    for (int i = 0; i < 3; i++) begin
      // leading whitespace and comments
      repeat ($urandom_range(2)) begin
        if ($urandom_range(3) == 0) begin
          f.push_back(CH_HASH);
          repeat ($urandom_range(3)) f.push_back(comment_byte());
          f.push_back(CH_LF);
        end else begin
          f.push_back(random_blank());
        end
      end
      style = $urandom_range(19);
      if (style == 0) begin
        f.push_back(random_stray());
        vals[i] = 0;
      end else begin
        if (style == 1) vals[i] = 65536 + $urandom_range(999999);
        if (style == 2) begin
          f.push_back(CH_0);
          f.push_back(CH_0);
        end
        txt = $sformatf("%0d", vals[i]);
        for (int k = 0; k < txt.len(); k++) f.push_back(txt[k]);
        // number terminator
        if (i < 2) begin
          case ($urandom_range(5))
            0: begin
              f.push_back(CH_HASH);
              repeat ($urandom_range(3)) f.push_back(comment_byte());
              f.push_back(CH_LF);
            end
            1: f.push_back(random_stray());
            default: f.push_back(random_blank());
          endcase
        end else if ($urandom_range(2) == 0) begin
          do begin
            b = 8'($urandom_range(255));
          end while (b >= CH_0 && b <= CH_9);
          f.push_back(b);
        end else begin
          f.push_back($urandom_range(4) == 0 ? CH_HASH : random_blank());
        end
      end
      if (vals[i] > 65535) vals[i] = 65535;
    end
    n_data = vals[0] * vals[1] * chans * ((vals[2] >= 256) ? 2 : 1);
    if (n_data > 40) n_data = $urandom_range(8);
    repeat (n_data) f.push_back(8'($urandom_range(255)));
    // broken files and trailing junk
    flaw = $urandom_range(11);
    if (flaw == 0) begin
      f[0] = 8'($urandom_range(255));
    end else if (flaw == 1) begin
      f[1] = 8'($urandom_range(255));
    end else if (flaw == 2) begin
      style = $urandom_range(f.size() - 1, 1);
      while (f.size() > style) f.delete(f.size() - 1);
    end else if (flaw == 3) begin
      repeat ($urandom_range(3, 1)) f.push_back(8'($urandom_range(255)));
    end
    foreach (f[i]) push_byte(f[i], i == 0);
  endtask

  // reset, directed cases, then random phases with different pacing
  initial begin
    int unsigned send_tbl[4] = '{0, 71, 0, 15};
    int unsigned recv_tbl[4] = '{0, 0, 71, 15};
    int unsigned mark;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no start after reset, hash as the maxval delimiter, one 8-bit sample
    push_text("P51 1 0#");
    push_byte(8'hff, 1'b0);
    // bad magic, ignored byte while idle, bad format digit
    push_byte("X", 1'b1);
    push_byte(CH_P, 1'b0);
    push_byte(CH_P, 1'b1);
    push_byte("7", 1'b0);
    // stray width, saturated height, hash after digits, empty image
    push_byte(CH_P, 1'b1);
    push_text("6x99999#");
    push_byte(CH_LF, 1'b0);
    push_text("1");
    push_byte(CH_CR, 1'b0);
    while (byte_q.size() != 0) @(posedge clk);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = send_tbl[p];
      recv_stall_pct = recv_tbl[p];
      // hold the sender once until every pending result is out
      if (p == 2) drain_next = 1'b1;
      mark = bytes_queued;
      while (bytes_queued - mark < PHASE_BYTES) add_random_file();
      while (byte_q.size() != 0) @(posedge clk);
    end

    while (in_valid || byte_q.size() != 0) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
